### rtl/core/sdi_pkg.sv
// Package for the spectrum double integral and edge search unit.
// Sizes, status codes, controller states and the controller/datapath command types.
// No dependencies.
package sdi_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);

  localparam int FIELD_W    = 24;
  localparam int INTEN_W    = 24;
  localparam int STEP_W     = FIELD_W + 1;
  localparam int PROD1_W    = INTEN_W + STEP_W;
  localparam int FIRST_W    = 58;
  localparam int SECOND_W   = 64;
  localparam int INDEX_W    = 11;
  localparam int STATUS_W   = 2;

  // split of |first| * |step| into two narrow products
  localparam int AHI_W      = FIRST_W - 32;
  localparam int HI_W       = AHI_W + FIELD_W;
  localparam int LO_W       = 32 + FIELD_W;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SAT   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_STEP,
    S_MUL1,
    S_FIRST,
    S_ABS,
    S_MULHI,
    S_MULLO,
    S_MAG,
    S_SECOND,
    S_FIRST_PT,
    S_FULL,
    S_SRCH_INIT,
    S_SRCH_EMPTY,
    S_SCHK,
    S_SCMP,
    S_SEND,
    S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_MUL1,
    CMD_FIRST,
    CMD_ABS,
    CMD_MULHI,
    CMD_MULLO,
    CMD_MAG,
    CMD_SECOND,
    CMD_FIRST_PT,
    CMD_FULL,
    CMD_SRCH_INIT,
    CMD_SRCH_EMPTY,
    CMD_SRCH_CMP,
    CMD_SRCH_END,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctrl_t;

  typedef struct packed {
    logic op_search;
    logic full;
    logic empty;
    logic lo_lt_hi;
  } sts_t;

endpackage

### rtl/core/sdi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/sdi_ctrl.sv
// Controller state machine of the spectrum double integral unit.
// Depends on sdi_pkg (state_t, ctrl_t, sts_t).
module sdi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sdi_pkg::sts_t sts,
  output sdi_pkg::ctrl_t ctrl,
  output logic          busy
);

  sdi_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdi_pkg::S_IDLE: begin
        if (start) state_nxt = sdi_pkg::S_DISP;
      end
      sdi_pkg::S_DISP: begin
        if (sts.op_search) begin
          state_nxt = sts.empty ? sdi_pkg::S_SRCH_EMPTY : sdi_pkg::S_SRCH_INIT;
        end else if (sts.full) begin
          state_nxt = sdi_pkg::S_FULL;
        end else if (sts.empty) begin
          state_nxt = sdi_pkg::S_FIRST_PT;
        end else begin
          state_nxt = sdi_pkg::S_STEP;
        end
      end
      sdi_pkg::S_STEP:       state_nxt = sdi_pkg::S_MUL1;
      sdi_pkg::S_MUL1:       state_nxt = sdi_pkg::S_FIRST;
      sdi_pkg::S_FIRST:      state_nxt = sdi_pkg::S_ABS;
      sdi_pkg::S_ABS:        state_nxt = sdi_pkg::S_MULHI;
      sdi_pkg::S_MULHI:      state_nxt = sdi_pkg::S_MULLO;
      sdi_pkg::S_MULLO:      state_nxt = sdi_pkg::S_MAG;
      sdi_pkg::S_MAG:        state_nxt = sdi_pkg::S_SECOND;
      sdi_pkg::S_SECOND:     state_nxt = sdi_pkg::S_EMIT;
      sdi_pkg::S_FIRST_PT:   state_nxt = sdi_pkg::S_EMIT;
      sdi_pkg::S_FULL:       state_nxt = sdi_pkg::S_EMIT;
      sdi_pkg::S_SRCH_EMPTY: state_nxt = sdi_pkg::S_EMIT;
      sdi_pkg::S_SRCH_INIT:  state_nxt = sdi_pkg::S_SCHK;
      sdi_pkg::S_SCHK: begin
        state_nxt = sts.lo_lt_hi ? sdi_pkg::S_SCMP : sdi_pkg::S_SEND;
      end
      sdi_pkg::S_SCMP:       state_nxt = sdi_pkg::S_SCHK;
      sdi_pkg::S_SEND:       state_nxt = sdi_pkg::S_EMIT;
      sdi_pkg::S_EMIT:       state_nxt = sdi_pkg::S_IDLE;
      default:               state_nxt = sdi_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl.cmd = sdi_pkg::CMD_NONE;
    case (state_r)
      sdi_pkg::S_IDLE: begin
        if (start) ctrl.cmd = sdi_pkg::CMD_LOAD;
      end
      sdi_pkg::S_STEP:       ctrl.cmd = sdi_pkg::CMD_STEP;
      sdi_pkg::S_MUL1:       ctrl.cmd = sdi_pkg::CMD_MUL1;
      sdi_pkg::S_FIRST:      ctrl.cmd = sdi_pkg::CMD_FIRST;
      sdi_pkg::S_ABS:        ctrl.cmd = sdi_pkg::CMD_ABS;
      sdi_pkg::S_MULHI:      ctrl.cmd = sdi_pkg::CMD_MULHI;
      sdi_pkg::S_MULLO:      ctrl.cmd = sdi_pkg::CMD_MULLO;
      sdi_pkg::S_MAG:        ctrl.cmd = sdi_pkg::CMD_MAG;
      sdi_pkg::S_SECOND:     ctrl.cmd = sdi_pkg::CMD_SECOND;
      sdi_pkg::S_FIRST_PT:   ctrl.cmd = sdi_pkg::CMD_FIRST_PT;
      sdi_pkg::S_FULL:       ctrl.cmd = sdi_pkg::CMD_FULL;
      sdi_pkg::S_SRCH_EMPTY: ctrl.cmd = sdi_pkg::CMD_SRCH_EMPTY;
      sdi_pkg::S_SRCH_INIT:  ctrl.cmd = sdi_pkg::CMD_SRCH_INIT;
      sdi_pkg::S_SCMP:       ctrl.cmd = sdi_pkg::CMD_SRCH_CMP;
      sdi_pkg::S_SEND:       ctrl.cmd = sdi_pkg::CMD_SRCH_END;
      sdi_pkg::S_EMIT:       ctrl.cmd = sdi_pkg::CMD_EMIT;
      default:               ctrl.cmd = sdi_pkg::CMD_NONE;
    endcase
  end

  assign busy = (state_r != sdi_pkg::S_IDLE);

endmodule

### rtl/core/sdi_dp.sv
// Datapath of the spectrum double integral unit: sums, multipliers, search pointers.
// Depends on sdi_pkg and sdi_ram (field store).
module sdi_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sdi_pkg::ctrl_t                         ctrl,
  output sdi_pkg::sts_t                          sts,
  input  logic                                   in_op,
  input  logic                                   in_start_set,
  input  logic [sdi_pkg::FIELD_W-1:0]            in_point_field,
  input  logic signed [sdi_pkg::INTEN_W-1:0]     in_point_intensity,
  input  logic [sdi_pkg::FIELD_W-1:0]            in_edge_field,
  output logic                                   out_valid,
  output logic signed [sdi_pkg::FIRST_W-1:0]     out_first_integral,
  output logic signed [sdi_pkg::SECOND_W-1:0]    out_second_integral,
  output logic [sdi_pkg::INDEX_W-1:0]            out_point_index,
  output logic [sdi_pkg::STATUS_W-1:0]           out_status
);

  localparam logic signed [sdi_pkg::FIRST_W-1:0] FIRST_MAX = {1'b0, {(sdi_pkg::FIRST_W-1){1'b1}}};
  localparam logic signed [sdi_pkg::FIRST_W-1:0] FIRST_MIN = {1'b1, {(sdi_pkg::FIRST_W-1){1'b0}}};
  localparam logic [sdi_pkg::SECOND_W-1:0]        BIAS      = {1'b1, {(sdi_pkg::SECOND_W-1){1'b0}}};

  // beat payload
  logic                                 op_r, op_nxt;
  logic [sdi_pkg::FIELD_W-1:0]          fld_r, fld_nxt;
  logic signed [sdi_pkg::INTEN_W-1:0]   inten_r, inten_nxt;
  logic [sdi_pkg::FIELD_W-1:0]          edge_r, edge_nxt;

  // spectrum state
  logic [sdi_pkg::CNT_W-1:0]            count_r, count_nxt;
  logic [sdi_pkg::FIELD_W-1:0]          last_r, last_nxt;
  logic signed [sdi_pkg::FIRST_W-1:0]   first_r, first_nxt;
  logic [sdi_pkg::SECOND_W-1:0]         second_r, second_nxt;

  // arithmetic pipeline
  logic signed [sdi_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic signed [sdi_pkg::PROD1_W-1:0]   prod1_r, prod1_nxt;
  logic [sdi_pkg::FIRST_W-1:0]          a_r, a_nxt;
  logic [sdi_pkg::FIELD_W-1:0]          b_r, b_nxt;
  logic                                 neg_r, neg_nxt;
  logic [sdi_pkg::HI_W-1:0]             hi_r, hi_nxt;
  logic [sdi_pkg::LO_W-1:0]             lo_r, lo_nxt;
  logic [sdi_pkg::SECOND_W-1:0]         mag_r, mag_nxt;

  // search pointers and result
  logic [sdi_pkg::CNT_W-1:0]            lo_idx_r, lo_idx_nxt;
  logic [sdi_pkg::CNT_W-1:0]            hi_idx_r, hi_idx_nxt;
  logic [sdi_pkg::CNT_W-1:0]            res_idx_r, res_idx_nxt;
  logic [sdi_pkg::STATUS_W-1:0]         stat_r, stat_nxt;

  logic                                 ov_r, ov_nxt;
  logic signed [sdi_pkg::FIRST_W-1:0]   of_r, of_nxt;
  logic [sdi_pkg::SECOND_W-1:0]         os_r, os_nxt;
  logic [sdi_pkg::INDEX_W-1:0]          oi_r, oi_nxt;
  logic [sdi_pkg::STATUS_W-1:0]         ost_r, ost_nxt;

  logic [sdi_pkg::CNT_W:0]              mid_sum;
  logic [sdi_pkg::CNT_W-1:0]            mid;
  logic [sdi_pkg::FIELD_W-1:0]          rd_data;
  logic                                 wr_en;

  logic signed [sdi_pkg::FIRST_W:0]     fsum;
  logic [sdi_pkg::SECOND_W-1:0]         biased;
  logic [sdi_pkg::SECOND_W:0]           bsum;
  logic [sdi_pkg::SECOND_W-1:0]         bres;
  logic                                 bclamp;

  assign mid_sum = {1'b0, lo_idx_r} + {1'b0, hi_idx_r};
  assign mid     = mid_sum[sdi_pkg::CNT_W:1];
  assign wr_en   = (ctrl.cmd == sdi_pkg::CMD_SECOND) || (ctrl.cmd == sdi_pkg::CMD_FIRST_PT);

  sdi_ram #(
    .WIDTH(sdi_pkg::FIELD_W),
    .DEPTH(sdi_pkg::MAX_POINTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[sdi_pkg::ADDR_W-1:0]),
    .wr_data(fld_r),
    .rd_addr(mid[sdi_pkg::ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  // first integral with clamp
  assign fsum = $signed({first_r[sdi_pkg::FIRST_W-1], first_r})
              + (sdi_pkg::FIRST_W+1)'(prod1_r);

  // second integral, biased add with clamp
  assign biased = second_r ^ BIAS;
  always_comb begin
    bsum   = {1'b0, biased} + {1'b0, mag_r};
    bres   = bsum[sdi_pkg::SECOND_W-1:0];
    bclamp = 1'b0;
    if (!neg_r) begin
      if (bsum[sdi_pkg::SECOND_W]) begin
        bres   = '1;
        bclamp = 1'b1;
      end
    end else begin
      if (mag_r > biased) begin
        bres   = '0;
        bclamp = 1'b1;
      end else begin
        bres = biased - mag_r;
      end
    end
  end

  always_comb begin
    op_nxt      = op_r;
    fld_nxt     = fld_r;
    inten_nxt   = inten_r;
    edge_nxt    = edge_r;
    count_nxt   = count_r;
    last_nxt    = last_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    step_nxt    = step_r;
    prod1_nxt   = prod1_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    neg_nxt     = neg_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    mag_nxt     = mag_r;
    lo_idx_nxt  = lo_idx_r;
    hi_idx_nxt  = hi_idx_r;
    res_idx_nxt = res_idx_r;
    stat_nxt    = stat_r;
    ov_nxt      = 1'b0;
    of_nxt      = of_r;
    os_nxt      = os_r;
    oi_nxt      = oi_r;
    ost_nxt     = ost_r;

    case (ctrl.cmd)
      sdi_pkg::CMD_LOAD: begin
        op_nxt    = in_op;
        fld_nxt   = in_point_field;
        inten_nxt = in_point_intensity;
        edge_nxt  = in_edge_field;
        if (!in_op && in_start_set) begin
          count_nxt  = '0;
          first_nxt  = '0;
          second_nxt = '0;
        end
      end
      sdi_pkg::CMD_STEP: begin
        step_nxt = $signed({1'b0, fld_r}) - $signed({1'b0, last_r});
      end
      sdi_pkg::CMD_MUL1: begin
        prod1_nxt = inten_r * step_r;
      end
      sdi_pkg::CMD_FIRST: begin
        if (fsum[sdi_pkg::FIRST_W] != fsum[sdi_pkg::FIRST_W-1]) begin
          first_nxt = fsum[sdi_pkg::FIRST_W] ? FIRST_MIN : FIRST_MAX;
        end else begin
          first_nxt = fsum[sdi_pkg::FIRST_W-1:0];
        end
      end
      sdi_pkg::CMD_ABS: begin
        a_nxt   = first_r[sdi_pkg::FIRST_W-1] ? (sdi_pkg::FIRST_W)'(-first_r)
                                              : (sdi_pkg::FIRST_W)'(first_r);
        b_nxt   = step_r[sdi_pkg::STEP_W-1] ? (sdi_pkg::FIELD_W)'(-step_r)
                                            : (sdi_pkg::FIELD_W)'(step_r);
        neg_nxt = first_r[sdi_pkg::FIRST_W-1] ^ step_r[sdi_pkg::STEP_W-1];
      end
      sdi_pkg::CMD_MULHI: begin
        hi_nxt = a_r[sdi_pkg::FIRST_W-1:32] * b_r;
      end
      sdi_pkg::CMD_MULLO: begin
        lo_nxt = a_r[31:0] * b_r;
      end
      sdi_pkg::CMD_MAG: begin
        if (|hi_r[sdi_pkg::HI_W-1:31]) begin
          mag_nxt = '1;
        end else begin
          mag_nxt = {hi_r[30:0], 32'd0} + (sdi_pkg::SECOND_W)'(lo_r);
        end
      end
      sdi_pkg::CMD_SECOND: begin
        second_nxt  = bres ^ BIAS;
        stat_nxt    = bclamp ? sdi_pkg::STAT_SAT : sdi_pkg::STAT_OK;
        res_idx_nxt = count_r;
        last_nxt    = fld_r;
        count_nxt   = count_r + 1'b1;
      end
      sdi_pkg::CMD_FIRST_PT: begin
        first_nxt   = '0;
        second_nxt  = '0;
        last_nxt    = fld_r;
        res_idx_nxt = '0;
        stat_nxt    = sdi_pkg::STAT_OK;
        count_nxt   = (sdi_pkg::CNT_W)'(1);
      end
      sdi_pkg::CMD_FULL: begin
        res_idx_nxt = count_r;
        stat_nxt    = sdi_pkg::STAT_FULL;
      end
      sdi_pkg::CMD_SRCH_EMPTY: begin
        res_idx_nxt = '0;
        stat_nxt    = sdi_pkg::STAT_EMPTY;
      end
      sdi_pkg::CMD_SRCH_INIT: begin
        lo_idx_nxt = '0;
        hi_idx_nxt = count_r;
      end
      sdi_pkg::CMD_SRCH_CMP: begin
        if (rd_data < edge_r) begin
          lo_idx_nxt = mid + 1'b1;
        end else begin
          hi_idx_nxt = mid;
        end
      end
      sdi_pkg::CMD_SRCH_END: begin
        res_idx_nxt = lo_idx_r;
        stat_nxt    = sdi_pkg::STAT_OK;
      end
      sdi_pkg::CMD_EMIT: begin
        ov_nxt  = 1'b1;
        of_nxt  = op_r ? '0 : first_r;
        os_nxt  = op_r ? '0 : second_r;
        oi_nxt  = (sdi_pkg::INDEX_W)'(res_idx_r);
        ost_nxt = stat_r;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      last_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    fld_r     <= fld_nxt;
    inten_r   <= inten_nxt;
    edge_r    <= edge_nxt;
    step_r    <= step_nxt;
    prod1_r   <= prod1_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    neg_r     <= neg_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    mag_r     <= mag_nxt;
    lo_idx_r  <= lo_idx_nxt;
    hi_idx_r  <= hi_idx_nxt;
    res_idx_r <= res_idx_nxt;
    stat_r    <= stat_nxt;
    of_r      <= of_nxt;
    os_r      <= os_nxt;
    oi_r      <= oi_nxt;
    ost_r     <= ost_nxt;
  end

  assign sts.op_search = op_r;
  assign sts.full      = (count_r == (sdi_pkg::CNT_W)'(sdi_pkg::MAX_POINTS));
  assign sts.empty     = (count_r == '0);
  assign sts.lo_lt_hi  = (lo_idx_r < hi_idx_r);

  assign out_valid           = ov_r;
  assign out_first_integral  = of_r;
  assign out_second_integral = os_r;
  assign out_point_index     = oi_r;
  assign out_status          = ost_r;

endmodule

### rtl/core/spectrum_double_integral_and_edge_search_unit.sv
// Spectrum double integral and edge search unit, top level; depends on sdi_pkg, sdi_ctrl, sdi_dp.
// One beat at a time; after dispatch, append runs step, product, first sum, absolute values,
//   high and low products, magnitude, second sum, emit; first point, dropped append, empty-store
//   search take one step and emit; search runs init, at most ceil(log2(n+1)) probes of one
//   registered store read each, end, emit; start is taken again in the cycle out_valid shows.
// Reset: synchronous, active low; empties the store, zeroes both sums, no result pending.
module spectrum_double_integral_and_edge_search_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input beat, taken when start is high and busy low
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_op,
  input  logic                                   in_start_set,
  input  logic [sdi_pkg::FIELD_W-1:0]            in_point_field,
  input  logic signed [sdi_pkg::INTEN_W-1:0]     in_point_intensity,
  input  logic [sdi_pkg::FIELD_W-1:0]            in_edge_field,
  // result beat, one cycle wide, cannot be held off
  output logic                                   out_valid,
  output logic signed [sdi_pkg::FIRST_W-1:0]     out_first_integral,
  output logic signed [sdi_pkg::SECOND_W-1:0]    out_second_integral,
  output logic [sdi_pkg::INDEX_W-1:0]            out_point_index,
  output logic [sdi_pkg::STATUS_W-1:0]           out_status
);

  sdi_pkg::ctrl_t ctrl;
  sdi_pkg::sts_t  sts;

  // Controller: sequences append (step, three multiplies, clamp) or the binary search.
  sdi_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .ctrl (ctrl),
    .busy (busy)
  );

  // Datapath: running sums, field store, lower-bound search pointers, result register.
  // The result register lets a new beat be taken while the last result is on the ports.
  sdi_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .sts                (sts),
    .in_op              (in_op),
    .in_start_set       (in_start_set),
    .in_point_field     (in_point_field),
    .in_point_intensity (in_point_intensity),
    .in_edge_field      (in_edge_field),
    .out_valid          (out_valid),
    .out_first_integral (out_first_integral),
    .out_second_integral(out_second_integral),
    .out_point_index    (out_point_index),
    .out_status         (out_status)
  );

endmodule

### rtl/core/sdi_chk.sv
// Port-level checker for the spectrum double integral unit, bound to the top level.
// Depends on sdi_pkg (status codes, sizes).
module sdi_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [sdi_pkg::FIRST_W-1:0]  out_first_integral,
  input logic signed [sdi_pkg::SECOND_W-1:0] out_second_integral,
  input logic [sdi_pkg::INDEX_W-1:0]         out_point_index,
  input logic [sdi_pkg::STATUS_W-1:0]        out_status
);

  // a result always closes a busy period, and the unit is free while it shows
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result beat outside end of busy period");

  a_fall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy ended without a result beat");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not make the unit busy");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sdi_pkg::STAT_EMPTY |->
      out_point_index == '0 && out_first_integral == '0 && out_second_integral == '0)
    else $error("empty search result not cleared");

  a_full_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sdi_pkg::STAT_FULL |->
      out_point_index == (sdi_pkg::INDEX_W)'(sdi_pkg::MAX_POINTS))
    else $error("dropped append reports wrong index");

endmodule

bind spectrum_double_integral_and_edge_search_unit sdi_chk u_sdi_chk (.*);

### bench/spectrum_double_integral_and_edge_search_unit_tb.sv
// Self-checking bench for the spectrum double integral and edge search unit.
// Predicts every result beat from its own copy of the point store and running sums.
// Depends on sdi_pkg and the unit's RTL only.
module spectrum_double_integral_and_edge_search_unit_tb;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [sdi_pkg::FIELD_W-1:0]        FIELD_TOP = '1;
  localparam logic signed [sdi_pkg::INTEN_W-1:0] INTEN_MAX = 24'sh7F_FFFF;
  localparam logic signed [sdi_pkg::INTEN_W-1:0] INTEN_MIN = 24'sh80_0000;

  // signed 58-bit rails of the first integral
  localparam longint FIRST_HI = 64'sh01FF_FFFF_FFFF_FFFF;
  localparam longint FIRST_LO = -FIRST_HI - 1;
  localparam logic [sdi_pkg::SECOND_W-1:0] SIGN64 = 64'h8000_0000_0000_0000;

  localparam int RANDOM_ITEMS  = 680;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [sdi_pkg::FIRST_W-1:0]  first;
    logic [sdi_pkg::SECOND_W-1:0] second;
    logic [sdi_pkg::INDEX_W-1:0]  idx;
    logic [sdi_pkg::STATUS_W-1:0] status;
  } point_result_t;

  // Running integrals, point store and the queue of results still owed by the unit.
  class spectrum_tracker;
    logic [sdi_pkg::FIELD_W-1:0]  fields [sdi_pkg::MAX_POINTS];
    int unsigned                  count;
    logic [sdi_pkg::FIELD_W-1:0]  last_fld;
    longint                       first_acc;
    logic [sdi_pkg::SECOND_W-1:0] second_acc;
    point_result_t                awaited [$];
    int unsigned                  mismatches;

    function new();
      count      = 0;
      last_fld   = '0;
      first_acc  = 0;
      second_acc = '0;
      mismatches = 0;
    endfunction

    // second += f * s with clamping; returns 1 on a clamp. The magnitude pins to
    // all ones once the upper partial product overflows, so an add from the far
    // rail can land on the opposite rail with no flag.
    function bit add_second(longint f, longint s);
      logic [63:0] a, b, hi, mag, biased;
      bit          neg, clamp;
      neg   = (f < 0) != (s < 0);
      a     = (f < 0) ? 64'(-f) : 64'(f);
      b     = (s < 0) ? 64'(-s) : 64'(s);
      hi    = (a >> 32) * b;
      clamp = 1'b0;
      if (hi >= 64'h8000_0000) begin
        mag = '1;
      end else begin
        mag = (hi << 32) + (a & 64'hFFFF_FFFF) * b;
      end
      biased = second_acc ^ SIGN64;
      if (!neg) begin
        if (mag > ~biased) begin
          biased = '1;
          clamp  = 1'b1;
        end else begin
          biased = biased + mag;
        end
      end else begin
        if (mag > biased) begin
          biased = '0;
          clamp  = 1'b1;
        end else begin
          biased = biased - mag;
        end
      end
      second_acc = biased ^ SIGN64;
      return clamp;
    endfunction

    function void take_item(logic op, logic start_set, logic [sdi_pkg::FIELD_W-1:0] fld,
                            logic signed [sdi_pkg::INTEN_W-1:0] inten,
                            logic [sdi_pkg::FIELD_W-1:0] edge_fld);
      point_result_t r;
      longint        step, f;
      int unsigned   idx, lo, hi, mid;
      r   = '0;
      idx = 0;
      if (op == OP_APPEND) begin
        if (start_set) begin
          count      = 0;
          first_acc  = 0;
          second_acc = '0;
        end
        if (count >= sdi_pkg::MAX_POINTS) begin
          // store full: beat dropped, sums carried unchanged
          r.status = sdi_pkg::STAT_FULL;
          idx      = count;
        end else if (count == 0) begin
          first_acc  = 0;
          second_acc = '0;
          fields[0]  = fld;
          last_fld   = fld;
          count      = 1;
        end else begin
          step = longint'(fld) - longint'(last_fld);  // may be negative
          f    = first_acc + longint'(inten) * step;
          if (f > FIRST_HI) f = FIRST_HI;
          if (f < FIRST_LO) f = FIRST_LO;
          first_acc = f;
          if (add_second(first_acc, step)) r.status = sdi_pkg::STAT_SAT;
          idx           = count;
          fields[count] = fld;
          last_fld      = fld;
          count++;
        end
        r.first  = first_acc[sdi_pkg::FIRST_W-1:0];
        r.second = second_acc;
      end else if (count == 0) begin
        r.status = sdi_pkg::STAT_EMPTY;
      end else begin
        // lower bound, run as a binary search even if the fields are unsorted
        lo = 0;
        hi = (count > sdi_pkg::MAX_POINTS) ? sdi_pkg::MAX_POINTS : count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (fields[mid] < edge_fld) lo = mid + 1;
          else hi = mid;
        end
        idx = lo;
      end
      r.idx = idx[sdi_pkg::INDEX_W-1:0];
      awaited.push_back(r);
    endfunction

    function void match_result(logic [sdi_pkg::FIRST_W-1:0] first_v,
                               logic [sdi_pkg::SECOND_W-1:0] second_v,
                               logic [sdi_pkg::INDEX_W-1:0] idx_v,
                               logic [sdi_pkg::STATUS_W-1:0] status_v);
      point_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: first %h second %h index %0d status %0d",
                   first_v, second_v, idx_v, status_v);
        return;
      end
      want = awaited.pop_front();
      if (want.first !== first_v || want.second !== second_v ||
          want.idx !== idx_v || want.status !== status_v) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: want first %h second %h index %0d status %0d",
                   want.first, want.second, want.idx, want.status);
          $display("                 got  first %h second %h index %0d status %0d",
                   first_v, second_v, idx_v, status_v);
        end
      end
    endfunction
  endclass

  logic                                clk   = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                in_op              = OP_APPEND;
  logic                                in_start_set       = 1'b0;
  logic [sdi_pkg::FIELD_W-1:0]         in_point_field     = '0;
  logic signed [sdi_pkg::INTEN_W-1:0]  in_point_intensity = '0;
  logic [sdi_pkg::FIELD_W-1:0]         in_edge_field      = '0;
  logic                                out_valid;
  logic signed [sdi_pkg::FIRST_W-1:0]  out_first_integral;
  logic signed [sdi_pkg::SECOND_W-1:0] out_second_integral;
  logic [sdi_pkg::INDEX_W-1:0]         out_point_index;
  logic [sdi_pkg::STATUS_W-1:0]        out_status;

  spectrum_tracker             tracker;
  int                          burst_left = 0;
  int                          items_sent = 0;
  int                          quiet      = 0;
  logic [sdi_pkg::FIELD_W-1:0] set_fields [$];  // fields of the current set, for picking edges

  always #1 clk = ~clk;

  spectrum_double_integral_and_edge_search_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_start_set        (in_start_set),
    .in_point_field      (in_point_field),
    .in_point_intensity  (in_point_intensity),
    .in_edge_field       (in_edge_field),
    .out_valid           (out_valid),
    .out_first_integral  (out_first_integral),
    .out_second_integral (out_second_integral),
    .out_point_index     (out_point_index),
    .out_status          (out_status)
  );

  // Monitor: results are checked before the beat taken at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.match_result(out_first_integral, out_second_integral,
                             out_point_index, out_status);
      if (start && !busy)
        tracker.take_item(in_op, in_start_set, in_point_field, in_point_intensity,
                          in_edge_field);
    end
  end

  // Watchdog on cycles with neither an input nor a result beat.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet = 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("spectrum_double_integral_and_edge_search_unit_tb: done, errors");
      $finish;
    end else begin
      quiet++;
    end
  end

  // Presents one beat and returns at the edge that takes it. Bursts of random
  // length are separated by random gaps so start rises at every phase of the work.
  task automatic offer_item(logic op, logic ss, logic [sdi_pkg::FIELD_W-1:0] fld,
                            logic [sdi_pkg::INTEN_W-1:0] inten,
                            logic [sdi_pkg::FIELD_W-1:0] edge_fld);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start              <= 1'b1;
    in_op              <= op;
    in_start_set       <= ss;
    in_point_field     <= fld;
    in_point_intensity <= inten;
    in_edge_field      <= edge_fld;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  task automatic append_point(logic ss, logic [sdi_pkg::FIELD_W-1:0] fld,
                              logic [sdi_pkg::INTEN_W-1:0] inten);
    if (ss) set_fields.delete();
    if (set_fields.size() < sdi_pkg::MAX_POINTS) set_fields.push_back(fld);
    offer_item(OP_APPEND, ss, fld, inten, sdi_pkg::FIELD_W'($urandom()));
  endtask

  task automatic search_edge(logic [sdi_pkg::FIELD_W-1:0] edge_fld);
    offer_item(OP_SEARCH, 1'($urandom_range(0, 1)), sdi_pkg::FIELD_W'($urandom()),
               sdi_pkg::INTEN_W'($urandom()), edge_fld);
  endtask

  // Holds the sender off until the unit owes nothing.
  task automatic await_results();
    start      <= 1'b0;
    burst_left  = 0;
    @(negedge clk);
    while (tracker.awaited.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Edge near a stored field, on it, at a rail or anywhere.
  function automatic logic [sdi_pkg::FIELD_W-1:0] pick_edge();
    logic [sdi_pkg::FIELD_W-1:0] f;
    if (set_fields.size() == 0) return sdi_pkg::FIELD_W'($urandom());
    f = set_fields[$urandom_range(0, set_fields.size() - 1)];
    case ($urandom_range(0, 5))
      0:       return f - 1'b1;
      1:       return f + 1'b1;
      2:       return '0;
      3:       return FIELD_TOP;
      4:       return sdi_pkg::FIELD_W'($urandom());
      default: return f;
    endcase
  endfunction

  initial begin
    logic [sdi_pkg::FIELD_W-1:0] fld;
    logic [sdi_pkg::INTEN_W-1:0] inten;
    logic                        ss;
    int                          n, stride, goal;
    bit                          quiet_inten;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats
    search_edge('0);                         // search before any point: empty store
    append_point(1'b0, '0, INTEN_MAX);       // first point without start_set
    append_point(1'b0, FIELD_TOP, INTEN_MAX); // widest step, second integral clamps high
    append_point(1'b0, '0, '0);              // huge negative step from the top rail
    append_point(1'b0, FIELD_TOP, INTEN_MIN);
    append_point(1'b0, 24'h80_0000, '1);     // field out of order, intensity -1
    search_edge('0);
    search_edge(FIELD_TOP);
    search_edge(24'h80_0000);
    search_edge(24'h00_0001);
    append_point(1'b1, 24'h00_0010, 24'd5);  // new set
    append_point(1'b0, 24'h00_0020, -24'sd7);
    append_point(1'b0, 24'h00_0020, INTEN_MAX); // zero step
    append_point(1'b0, 24'h00_0100, INTEN_MIN);
    search_edge(24'h00_0010);
    search_edge(24'h00_0011);
    search_edge(24'h00_0020);
    search_edge(24'h00_0021);
    search_edge(24'h00_0101);                // past the last point: returns the count
    append_point(1'b1, '0, INTEN_MIN);
    append_point(1'b0, FIELD_TOP, INTEN_MIN); // second integral clamps low
    search_edge(24'h7F_FFFF);
    await_results();

    // Random part: mostly well-formed sets with random content, some noise
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          append_point(1'($urandom_range(0, 1)), sdi_pkg::FIELD_W'($urandom()),
                       sdi_pkg::INTEN_W'($urandom()));
        else
          search_edge(sdi_pkg::FIELD_W'($urandom()));
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        case ($urandom_range(0, 2))
          0:       stride = 16;
          1:       stride = 4096;
          default: stride = 16777215 / n;
        endcase
        fld         = ($urandom_range(0, 3) == 0) ? '0
                                                  : sdi_pkg::FIELD_W'($urandom_range(0, 8388607));
        quiet_inten = $urandom_range(0, 1);
        ss          = ($urandom_range(0, 7) != 0);  // sometimes carry on the last set
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 11) == 0) fld = sdi_pkg::FIELD_W'($urandom());
          else if (i > 0) fld = fld + sdi_pkg::FIELD_W'($urandom_range(0, stride));
          inten = quiet_inten ? sdi_pkg::INTEN_W'($urandom_range(0, 127) - 64)
                              : sdi_pkg::INTEN_W'($urandom());
          append_point(ss && i == 0, fld, inten);
          if ($urandom_range(0, 3) == 0) search_edge(pick_edge());
        end
        repeat ($urandom_range(1, 3)) search_edge(pick_edge());
        if ($urandom_range(0, 19) == 0) await_results();
      end
    end

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
      $display("spectrum_double_integral_and_edge_search_unit_tb: done, clean");
    else
      $display("spectrum_double_integral_and_edge_search_unit_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/core/sdi_pkg.sv
rtl/core/sdi_ram.sv
rtl/core/sdi_ctrl.sv
rtl/core/sdi_dp.sv
rtl/core/spectrum_double_integral_and_edge_search_unit.sv
rtl/core/sdi_chk.sv
bench/spectrum_double_integral_and_edge_search_unit_tb.sv
